// ===== rtl/core/gpm_pkg.sv =====
package gpm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int SUBJECT_MAX = 256;

    localparam int PL_W = $clog2(PATTERN_MAX + 1);
    localparam int PA_W = $clog2(PATTERN_MAX);
    localparam int SL_W = $clog2(SUBJECT_MAX + 1);
    localparam int SA_W = $clog2(SUBJECT_MAX);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_BSLH  = 8'h5C;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFS   = 8'h20;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP,
        S_DEC,
        S_LIT,
        S_BANG,
        S_CL_RD,
        S_CL_CHK,
        S_CL_DASH,
        S_CL_HI,
        S_CL_END,
        S_FAIL,
        S_TL_RD,
        S_TL_CHK,
        S_DONE
    } t_state;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            r = b + CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/glob_pattern_matcher_core.sv =====
// Channel   Direction  Word                  Handshake
// -------   ---------  --------------------  ---------------------------
// in        input      gpm_pkg::t_in_word    i_in_valid / o_in_stall
// out       output     gpm_pkg::t_out_word   o_out_valid / i_out_stall
// cfg       input      i_cfg_data (1 bit)    i_cfg_we, no wait
//
// A pattern or subject word loads while the block is idle. The last subject
// word starts the walk unless an overflow was seen; it steps through pattern
// and subject, and through bracket class elements, repeating steps after each
// backtrack to a star; the pattern memory's single read port sets its pace.
// i_rst_n is synchronous, active low; it empties the pattern and subject.
// o_in_stall is high from the start of a walk until its result is registered;
// the result waits in the output register while new words load.
module glob_pattern_matcher_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gpm_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gpm_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data
);
    import gpm_pkg::*;

    logic [7:0] r_pat_mem  [PATTERN_MAX];
    logic [7:0] r_subj_mem [SUBJECT_MAX];
    logic [7:0] r_pdata;
    logic [7:0] r_sdata;

    t_state            r_state, n_state;
    logic [PL_W-1:0]   r_pat_len, n_pat_len;
    logic              r_pat_complete, n_pat_complete;
    logic              r_pat_tl, n_pat_tl;
    logic [SL_W-1:0]   r_subj_len, n_subj_len;
    logic              r_subj_tl, n_subj_tl;
    logic              r_fold_case;
    logic [PL_W-1:0]   r_p, n_p;
    logic [PL_W-1:0]   r_back_p, n_back_p;
    logic [SL_W-1:0]   r_s, n_s;
    logic [SL_W-1:0]   r_back_s, n_back_s;
    logic              r_have_star, n_have_star;
    logic              r_inv, n_inv;
    logic              r_hit, n_hit;
    logic signed [7:0] r_sc, n_sc;
    logic signed [7:0] r_lo, n_lo;
    logic              r_match, n_match;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic              w_pat_we;
    logic              w_subj_we;
    logic [PA_W-1:0]   w_praddr;
    logic [PL_W-1:0]   w_pat_base;
    logic              w_pat_tl_base;
    logic              w_pat_room;
    logic              w_subj_room;
    logic [PL_W-1:0]   w_p1;
    logic [PL_W:0]     w_p2;
    logic              w_p_lt;
    logic              w_p1_lt;
    logic              w_p2_lt;
    logic [7:0]        w_pcf;
    logic signed [7:0] w_pcs;
    logic [7:0]        w_scf;

    assign w_pat_base    = r_pat_complete ? '0 : r_pat_len;
    assign w_pat_tl_base = r_pat_complete ? 1'b0 : r_pat_tl;
    assign w_pat_room    = w_pat_base < PL_W'(PATTERN_MAX);
    assign w_subj_room   = r_subj_len < SL_W'(SUBJECT_MAX);
    assign w_p1          = r_p + PL_W'(1);
    assign w_p2          = {1'b0, r_p} + (PL_W + 1)'(2);
    assign w_p_lt        = r_p < r_pat_len;
    assign w_p1_lt       = {1'b0, r_p} + (PL_W + 1)'(1) < {1'b0, r_pat_len};
    assign w_p2_lt       = w_p2 < {1'b0, r_pat_len};
    assign w_pcf         = fold_byte(r_pdata, r_fold_case);
    assign w_pcs         = signed'(w_pcf);
    assign w_scf         = fold_byte(r_sdata, r_fold_case);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_pat_we) begin
            r_pat_mem[w_pat_base[PA_W-1:0]] <= i_in_word.data_byte;
        end
        r_pdata <= r_pat_mem[w_praddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_subj_we) begin
            r_subj_mem[r_subj_len[SA_W-1:0]] <= i_in_word.data_byte;
        end
        r_sdata <= r_subj_mem[r_s[SA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pat_len      <= '0;
            r_pat_complete <= 1'b1;
            r_pat_tl       <= 1'b0;
            r_subj_len     <= '0;
            r_subj_tl      <= 1'b0;
            r_fold_case    <= 1'b0;
            r_p            <= '0;
            r_back_p       <= '0;
            r_s            <= '0;
            r_back_s       <= '0;
            r_have_star    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pat_len      <= n_pat_len;
            r_pat_complete <= n_pat_complete;
            r_pat_tl       <= n_pat_tl;
            r_subj_len     <= n_subj_len;
            r_subj_tl      <= n_subj_tl;
            r_p            <= n_p;
            r_back_p       <= n_back_p;
            r_s            <= n_s;
            r_back_s       <= n_back_s;
            r_have_star    <= n_have_star;
            r_out_valid    <= n_out_valid;
            if (i_cfg_we) begin
                r_fold_case <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv      <= n_inv;
        r_hit      <= n_hit;
        r_sc       <= n_sc;
        r_lo       <= n_lo;
        r_match    <= n_match;
        r_ovf      <= n_ovf;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state        = r_state;
        n_pat_len      = r_pat_len;
        n_pat_complete = r_pat_complete;
        n_pat_tl       = r_pat_tl;
        n_subj_len     = r_subj_len;
        n_subj_tl      = r_subj_tl;
        n_p            = r_p;
        n_back_p       = r_back_p;
        n_s            = r_s;
        n_back_s       = r_back_s;
        n_have_star    = r_have_star;
        n_inv          = r_inv;
        n_hit          = r_hit;
        n_sc           = r_sc;
        n_lo           = r_lo;
        n_match        = r_match;
        n_ovf          = r_ovf;
        n_out_word     = r_out_word;
        n_out_valid    = r_out_valid && i_out_stall;
        w_pat_we       = 1'b0;
        w_subj_we      = 1'b0;
        w_praddr       = r_p[PA_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_word.func) begin
                        // a word after a finished pattern starts a new one
                        n_pat_len = w_pat_base;
                        n_pat_tl  = w_pat_tl_base;
                        if (i_in_word.has_byte) begin
                            if (w_pat_room) begin
                                w_pat_we  = 1'b1;
                                n_pat_len = w_pat_base + PL_W'(1);
                            end else begin
                                n_pat_tl = 1'b1;
                            end
                        end
                        n_pat_complete = i_in_word.last;
                    end else begin
                        if (i_in_word.has_byte) begin
                            if (w_subj_room) begin
                                w_subj_we  = 1'b1;
                                n_subj_len = r_subj_len + SL_W'(1);
                            end else begin
                                n_subj_tl = 1'b1;
                            end
                        end
                        if (i_in_word.last) begin
                            n_p         = '0;
                            n_s         = '0;
                            n_have_star = 1'b0;
                            n_ovf       = r_pat_tl || n_subj_tl;
                            if (r_pat_tl || n_subj_tl) begin
                                n_match = 1'b0;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_TOP;
                            end
                        end
                    end
                end
            end
            S_TOP: begin
                if (r_s < r_subj_len) begin
                    n_state = S_DEC;
                end else begin
                    n_state = S_TL_RD;
                end
            end
            S_DEC: begin
                n_sc = signed'(w_scf);
                if (!w_p_lt) begin
                    n_state = S_FAIL;
                end else if (r_pdata == CH_STAR) begin
                    n_have_star = 1'b1;
                    n_back_p    = r_p;
                    n_back_s    = r_s;
                    n_p         = w_p1;
                    n_state     = S_TOP;
                end else if (r_pdata == CH_QUES) begin
                    n_p     = w_p1;
                    n_s     = r_s + SL_W'(1);
                    n_state = S_TOP;
                end else if (r_pdata == CH_LBRK) begin
                    n_inv    = 1'b0;
                    n_hit    = 1'b0;
                    n_p      = w_p1;
                    w_praddr = w_p1[PA_W-1:0];
                    n_state  = S_BANG;
                end else if (r_pdata == CH_BSLH && w_p1_lt) begin
                    // escaped byte: fetch the next one and compare it plainly
                    n_p      = w_p1;
                    w_praddr = w_p1[PA_W-1:0];
                    n_state  = S_LIT;
                end else if (w_pcf == w_scf) begin
                    n_p     = w_p1;
                    n_s     = r_s + SL_W'(1);
                    n_state = S_TOP;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_LIT: begin
                if (w_pcf == 8'(r_sc)) begin
                    n_p     = w_p1;
                    n_s     = r_s + SL_W'(1);
                    n_state = S_TOP;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_BANG: begin
                if (w_p_lt && r_pdata == CH_BANG) begin
                    n_inv = 1'b1;
                    n_p   = w_p1;
                end
                n_state = S_CL_RD;
            end
            S_CL_RD: begin
                if (w_p_lt) begin
                    n_state = S_CL_CHK;
                end else begin
                    n_state = S_CL_END;
                end
            end
            S_CL_CHK: begin
                if (r_pdata == CH_RBRK) begin
                    n_state = S_CL_END;
                end else begin
                    n_lo = w_pcs;
                    if (w_p2_lt) begin
                        w_praddr = w_p1[PA_W-1:0];
                        n_state  = S_CL_DASH;
                    end else begin
                        n_hit   = r_hit || (r_sc == w_pcs);
                        n_p     = w_p1;
                        n_state = S_CL_RD;
                    end
                end
            end
            S_CL_DASH: begin
                if (r_pdata == CH_DASH) begin
                    w_praddr = w_p2[PA_W-1:0];
                    n_state  = S_CL_HI;
                end else begin
                    n_hit   = r_hit || (r_sc == r_lo);
                    n_p     = w_p1;
                    n_state = S_CL_RD;
                end
            end
            S_CL_HI: begin
                if (r_pdata != CH_RBRK) begin
                    n_hit = r_hit || (r_sc >= r_lo && r_sc <= w_pcs);
                    n_p   = r_p + PL_W'(3);
                end else begin
                    n_hit = r_hit || (r_sc == r_lo);
                    n_p   = w_p1;
                end
                n_state = S_CL_RD;
            end
            S_CL_END: begin
                // step over the closing bracket when there is one
                if (w_p_lt) begin
                    n_p = w_p1;
                end
                if (r_hit != r_inv) begin
                    n_s     = r_s + SL_W'(1);
                    n_state = S_TOP;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_FAIL: begin
                if (!r_have_star) begin
                    n_match = 1'b0;
                    n_state = S_DONE;
                end else begin
                    // backtrack: let the last star eat one more subject byte
                    n_p      = r_back_p + PL_W'(1);
                    n_back_s = r_back_s + SL_W'(1);
                    n_s      = r_back_s + SL_W'(1);
                    n_state  = S_TOP;
                end
            end
            S_TL_RD: begin
                if (w_p_lt) begin
                    n_state = S_TL_CHK;
                end else begin
                    n_match = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_TL_CHK: begin
                if (r_pdata == CH_STAR) begin
                    n_p     = w_p1;
                    n_state = S_TL_RD;
                end else begin
                    n_match = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out_word.matched  = r_match;
                    n_out_word.overflow = r_ovf;
                    n_subj_len          = '0;
                    n_subj_tl           = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_p_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_p <= r_pat_len))
        else $error("pattern index beyond pattern length");

    a_s_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_s <= r_subj_len))
        else $error("subject index beyond subject length");

    a_back_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_have_star) |-> (r_back_s <= r_s && r_back_p < r_p))
        else $error("backtrack point ahead of walk position");

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done step");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_word.overflow && r_out_word.matched))
        else $error("overflow result reports a match");

endmodule

// ===== sim/tb_glob_pattern_matcher_core.sv =====
module tb_glob_pattern_matcher_core;
    import gpm_pkg::*;

    typedef logic [7:0] t_byte_q [$];

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_stall = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_data = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // predictor state
    logic [7:0] pat_mem [PATTERN_MAX];
    int         pat_len;
    bit         pat_closed;
    bit         pat_ovf;
    logic [7:0] subj_mem [SUBJECT_MAX];
    int         subj_len;
    bit         subj_ovf;
    bit         fold_en;

    t_out_word expected_verdicts [$];
    int        err_count = 0;
    int        verdicts_seen = 0;
    int        words_sent = 0;
    int        nobyte_pct = 0;
    bit        idle_on = 1'b1;
    int        hold_cnt = 0;

    glob_pattern_matcher_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void reset_model();
        pat_len    = 0;
        pat_closed = 1'b1;
        pat_ovf    = 1'b0;
        subj_len   = 0;
        subj_ovf   = 1'b0;
        fold_en    = 1'b0;
    endfunction

    function automatic logic [7:0] folded(logic [7:0] b);
        if (fold_en && b >= "A" && b <= "Z") begin
            return b + 8'd32;
        end
        return b;
    endfunction

    // backtracking walk, remembers only the latest star
    function automatic bit glob_walk();
        int p, s, back_p, back_s, lo, hi, sc;
        bit star, inv, hit;
        p = 0;
        s = 0;
        back_p = 0;
        back_s = 0;
        star = 1'b0;
        while (s < subj_len) begin
            if (p < pat_len && pat_mem[p] == CH_STAR) begin
                star = 1'b1;
                back_p = p;
                back_s = s;
                p++;
                continue;
            end
            if (p < pat_len && pat_mem[p] == CH_QUES) begin
                p++;
                s++;
                continue;
            end
            if (p < pat_len && pat_mem[p] == CH_LBRK) begin
                inv = 1'b0;
                hit = 1'b0;
                sc = $signed(folded(subj_mem[s]));
                p++;
                if (p < pat_len && pat_mem[p] == CH_BANG) begin
                    inv = 1'b1;
                    p++;
                end
                while (p < pat_len && pat_mem[p] != CH_RBRK) begin
                    lo = $signed(folded(pat_mem[p]));
                    if (p + 2 < pat_len && pat_mem[p + 1] == CH_DASH &&
                        pat_mem[p + 2] != CH_RBRK) begin
                        hi = $signed(folded(pat_mem[p + 2]));
                        if (sc >= lo && sc <= hi) hit = 1'b1;
                        p += 3;
                    end else begin
                        if (sc == lo) hit = 1'b1;
                        p++;
                    end
                end
                if (p < pat_len) p++;
                if (hit != inv) begin
                    s++;
                    continue;
                end
            end else if (p < pat_len) begin
                if (pat_mem[p] == CH_BSLH && p + 1 < pat_len) p++;
                if (folded(pat_mem[p]) == folded(subj_mem[s])) begin
                    p++;
                    s++;
                    continue;
                end
            end
            if (!star) return 1'b0;
            p = back_p + 1;
            back_s++;
            s = back_s;
        end
        while (p < pat_len && pat_mem[p] == CH_STAR) p++;
        return p == pat_len;
    endfunction

    function automatic void apply_word(t_in_word w);
        t_out_word v;
        if (!w.func) begin
            if (pat_closed) begin
                pat_len = 0;
                pat_ovf = 1'b0;
            end
            if (w.has_byte) begin
                if (pat_len < PATTERN_MAX) begin
                    pat_mem[pat_len] = w.data_byte;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
            end
            pat_closed = w.last;
        end else begin
            if (w.has_byte) begin
                if (subj_len < SUBJECT_MAX) begin
                    subj_mem[subj_len] = w.data_byte;
                    subj_len++;
                end else begin
                    subj_ovf = 1'b1;
                end
            end
            if (w.last) begin
                v.overflow = pat_ovf || subj_ovf;
                v.matched  = v.overflow ? 1'b0 : glob_walk();
                expected_verdicts.push_back(v);
                subj_len = 0;
                subj_ovf = 1'b0;
            end
        end
    endfunction

    function automatic void check_verdict(t_out_word got);
        t_out_word want;
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
            err_count++;
            if (err_count <= 10) begin
                $display("unexpected verdict matched=%0b overflow=%0b",
                         got.matched, got.overflow);
            end
            return;
        end
        want = expected_verdicts.pop_front();
        if (got.matched !== want.matched || got.overflow !== want.overflow) begin
            err_count++;
            if (err_count <= 10) begin
                $display("verdict %0d: expected matched=%0b overflow=%0b, got %0b %0b",
                         verdicts_seen, want.matched, want.overflow,
                         got.matched, got.overflow);
            end
        end
    endfunction

    // take results; after each one hold stall for a random number of valid cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_verdict(o_out_word);
                hold_cnt = idle_on ? $urandom_range(0, 7) : 0;
            end else if (o_out_valid && hold_cnt != 0) begin
                hold_cnt--;
            end
            out_stall <= (hold_cnt != 0);
        end
    end

    // valid is left high on return so the next word can follow without a gap
    task automatic send_word(t_in_word w);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        apply_word(w);
        words_sent++;
    endtask

    task automatic send_bytes(bit to_subject, t_byte_q q, bit closing);
        t_in_word w;
        int i;
        w.func = to_subject;
        for (i = 0; i < q.size(); i++) begin
            if ($urandom_range(0, 99) < nobyte_pct) begin
                w.data_byte = $urandom_range(0, 255);
                w.has_byte  = 1'b0;
                w.last      = 1'b0;
                send_word(w);
            end
            w.data_byte = q[i];
            w.has_byte  = 1'b1;
            w.last      = closing && (i == q.size() - 1);
            send_word(w);
        end
        if (q.size() == 0 && closing) begin
            w.data_byte = $urandom_range(0, 255);
            w.has_byte  = 1'b0;
            w.last      = 1'b1;
            send_word(w);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_fold(bit v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        fold_en = v;
    endtask

    function automatic t_byte_q txt(string s);
        t_byte_q q;
        int i;
        for (i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    task automatic check_pair(string p, string s);
        send_bytes(1'b0, txt(p), 1'b1);
        send_bytes(1'b1, txt(s), 1'b1);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] common [8] = '{"a", "A", "b", "B", "c", CH_DASH, CH_RBRK, CH_BANG};
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 255);
        return common[$urandom_range(0, 7)];
    endfunction

    // build a random glob and a subject that should mostly match it
    function automatic void make_glob(output t_byte_q pat, output t_byte_q hit);
        int ntok;
        logic [7:0] a, b, x;
        pat = {};
        hit = {};
        ntok = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
        repeat (ntok) begin
            a = pick_char();
            b = pick_char();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    pat.push_back(a);
                    hit.push_back(a);
                end
                4: begin
                    pat.push_back(CH_QUES);
                    hit.push_back(b);
                end
                5, 6: begin
                    pat.push_back(CH_STAR);
                    repeat ($urandom_range(0, 2)) hit.push_back(pick_char());
                end
                7, 8: begin
                    pat.push_back(CH_LBRK);
                    if ($urandom_range(0, 2) == 0) pat.push_back(CH_BANG);
                    pat.push_back(a);
                    if ($urandom_range(0, 1) == 0) begin
                        pat.push_back(CH_DASH);
                        pat.push_back(b);
                    end
                    if ($urandom_range(0, 2) == 0) pat.push_back(pick_char());
                    if ($urandom_range(0, 9) != 0) pat.push_back(CH_RBRK);
                    hit.push_back(a);
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: x = CH_STAR;
                        1: x = CH_QUES;
                        2: x = CH_LBRK;
                        3: x = CH_BSLH;
                        default: x = a;
                    endcase
                    pat.push_back(CH_BSLH);
                    pat.push_back(x);
                    hit.push_back(x);
                end
            endcase
        end
    endfunction

    function automatic t_byte_q make_subject(t_byte_q hit);
        t_byte_q s;
        int pos;
        s = hit;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                foreach (s[i]) begin
                    if ($urandom_range(0, 3) == 0 &&
                        (s[i] | 8'h20) >= "a" && (s[i] | 8'h20) <= "z") s[i] ^= 8'h20;
                end
            end
            5, 6: begin
                if (s.size() == 0) begin
                    s.push_back(pick_char());
                end else begin
                    pos = $urandom_range(0, s.size() - 1);
                    case ($urandom_range(0, 2))
                        0: s[pos] = pick_char();
                        1: s.delete(pos);
                        default: s.insert(pos, pick_char());
                    endcase
                end
            end
            7, 8: begin
                s = {};
                repeat ($urandom_range(0, 8)) s.push_back(pick_char());
            end
            default: begin
                s = {};
                if ($urandom_range(0, 3) == 0) begin
                    repeat (SUBJECT_MAX - 1 + $urandom_range(0, 3)) s.push_back(pick_char());
                end
            end
        endcase
        return s;
    endfunction

    task automatic test_reset_defaults();
        send_bytes(1'b1, txt(""), 1'b1);
        send_bytes(1'b1, txt("a"), 1'b1);
        drain();
    endtask

    task automatic test_wildcards();
        check_pair("a*b?c", "axxbyc");
        send_bytes(1'b1, txt("abc"), 1'b1);
        send_bytes(1'b1, txt("ab-c"), 1'b1);
        check_pair("*a*b", "aaaab");
        check_pair("ab**", "ab");
        check_pair("*", "");
        check_pair("?", "");
        check_pair("", "");
        drain();
    endtask

    task automatic test_classes();
        t_byte_q q;
        check_pair("[a-c]x", "bx");
        check_pair("[!a-c]x", "bx");
        check_pair("[]a", "a");
        check_pair("[!]a", "xa");
        check_pair("[ab", "b");
        check_pair("[a-]", "-");
        // range bounds compare as signed bytes
        q = '{CH_LBRK, 8'h80, CH_DASH, 8'h7F, CH_RBRK};
        send_bytes(1'b0, q, 1'b1);
        q = '{8'hFF};
        send_bytes(1'b1, q, 1'b1);
        q = '{8'h00};
        send_bytes(1'b1, q, 1'b1);
        q = '{CH_LBRK, "a", CH_DASH, 8'h80, CH_RBRK};
        send_bytes(1'b0, q, 1'b1);
        send_bytes(1'b1, txt("b"), 1'b1);
        drain();
    endtask

    task automatic test_escapes_and_gaps();
        check_pair("\\*b", "*b");
        send_bytes(1'b1, txt("xb"), 1'b1);
        check_pair("a\\", "a\\");
        check_pair("\\\\", "\\");
        // words without a byte ahead of every byte
        nobyte_pct = 100;
        check_pair("ab", "ab");
        nobyte_pct = 0;
        send_bytes(1'b0, txt(""), 1'b1);
        send_bytes(1'b1, txt(""), 1'b1);
        send_bytes(1'b1, txt("q"), 1'b1);
        drain();
    endtask

    task automatic test_split_pattern();
        send_bytes(1'b0, txt("a*"), 1'b0);
        send_bytes(1'b1, txt("abc"), 1'b1);
        send_bytes(1'b0, txt("c"), 1'b1);
        send_bytes(1'b1, txt("abc"), 1'b1);
        send_bytes(1'b1, txt("abd"), 1'b1);
        drain();
    endtask

    task automatic test_case_fold();
        set_fold(1'b1);
        check_pair("A[B-C]?", "abz");
        check_pair("[Z-a]", "z");
        check_pair("x\\Q", "XQ");
        set_fold(1'b0);
        check_pair("A", "a");
        check_pair("[Z-a]", "_");
        drain();
    endtask

    task automatic test_overflow();
        t_byte_q q;
        q = {};
        repeat (PATTERN_MAX) q.push_back(CH_STAR);
        send_bytes(1'b0, q, 1'b1);
        q = {};
        repeat (SUBJECT_MAX) q.push_back("x");
        send_bytes(1'b1, q, 1'b1);
        q.push_back("x");
        send_bytes(1'b1, q, 1'b1);
        send_bytes(1'b1, txt("x"), 1'b1);
        q = {};
        repeat (PATTERN_MAX + 1) q.push_back("a");
        send_bytes(1'b0, q, 1'b1);
        send_bytes(1'b1, txt("a"), 1'b1);
        send_bytes(1'b1, txt(""), 1'b1);
        q.delete(0);
        send_bytes(1'b0, q, 1'b1);
        send_bytes(1'b1, q, 1'b1);
        check_pair("a", "a");
        drain();
    endtask

    task automatic test_random_globs(int quota);
        t_byte_q pat, hit, head, tail;
        int k;
        while (words_sent < quota) begin
            make_glob(pat, hit);
            if ($urandom_range(0, 24) == 0) begin
                pat = {};
                repeat (PATTERN_MAX - 1 + $urandom_range(0, 3)) pat.push_back(pick_char());
            end
            if ($urandom_range(0, 9) == 0 && pat.size() > 1) begin
                // subject arrives while the pattern is still open
                k = $urandom_range(1, pat.size() - 1);
                head = {};
                tail = {};
                foreach (pat[i]) begin
                    if (i < k) head.push_back(pat[i]);
                    else tail.push_back(pat[i]);
                end
                send_bytes(1'b0, head, 1'b0);
                send_bytes(1'b1, make_subject(hit), 1'b1);
                send_bytes(1'b0, tail, 1'b1);
            end else begin
                send_bytes(1'b0, pat, 1'b1);
            end
            repeat ($urandom_range(1, 4)) send_bytes(1'b1, make_subject(hit), 1'b1);
        end
        drain();
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_wildcards();
        test_classes();
        test_escapes_and_gaps();
        test_split_pattern();
        test_case_fold();
        test_overflow();

        words_sent = 0;
        nobyte_pct = 5;
        test_random_globs(190);
        set_fold(1'b1);
        test_random_globs(380);
        idle_on = 1'b0;
        test_random_globs(570);
        idle_on = 1'b1;
        set_fold(1'b0);
        test_random_globs(750);

        drain();
        repeat (16) @(posedge clk);
        $display("covered %0d random words, %0d verdicts checked, %0d errors",
                 words_sent, verdicts_seen, err_count);
        $display("folding off and on, open patterns, overlong pattern and subject");
        if (err_count == 0 && expected_verdicts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gpm_pkg.sv
rtl/core/glob_pattern_matcher_core.sv
sim/tb_glob_pattern_matcher_core.sv
